/* rtl/ihe_pkg.sv */
// Shared sizes, codes, types and helper functions of the integral histogram engine.
package ihe_pkg;

  // Table limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_BINS   = 64;

  // Index and counter widths derived from the limits
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
  localparam int BCNT_W = $clog2(MAX_BINS + 1);
  localparam int ADDR_W = BIN_W + ROW_W + COL_W;

  // Fixed field widths
  localparam int CNT_W     = 13;
  localparam int LABEL_W   = 10;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int WREG_W    = 7;
  localparam int HREG_W    = 7;
  localparam int BREG_W    = 11;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BINS   = 2'd2;

  // Kind of read response in flight
  typedef enum logic [1:0] {
    RSP_DG   = 2'd0,
    RSP_CELL = 2'd1,
    RSP_Q1   = 2'd2,
    RSP_Q2   = 2'd3
  } rsp_op_e;

  // Active sizes after clamping
  typedef struct packed {
    logic [WCNT_W-1:0] width;
    logic [HCNT_W-1:0] height;
    logic [BCNT_W-1:0] num_bins;
  } cfg_t;

  // One input beat
  typedef struct packed {
    logic               kind;
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] bottom_row;
    logic [LABEL_W-1:0] query_bin;
  } item_t;

  // Table access of one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  // Map zero to one and anything above the limit to the limit
  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v, input int limit);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (32'(v) > limit) r = CFG_W'(limit);
    else r = v;
    return r;
  endfunction

  // Pull a query column onto the last table column when out of range
  function automatic logic [COL_W-1:0] clamp_col(input logic [COORD_W-1:0] v);
    logic [COL_W-1:0] r;
    if (32'(v) >= MAX_WIDTH) r = COL_W'(MAX_WIDTH - 1);
    else r = COL_W'(v);
    return r;
  endfunction

  // Pull a query row onto the last table row when out of range
  function automatic logic [ROW_W-1:0] clamp_row(input logic [COORD_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (32'(v) >= MAX_HEIGHT) r = ROW_W'(MAX_HEIGHT - 1);
    else r = ROW_W'(v);
    return r;
  endfunction

endpackage

/* rtl/ihe_table_ram.sv */
// Integral count table: one write port and two registered read ports.
module ihe_table_ram (
  input  logic                      clk_i,
  input  ihe_pkg::mem_req_t         req_i,
  output logic [ihe_pkg::CNT_W-1:0] rd_a_o,
  output logic [ihe_pkg::CNT_W-1:0] rd_b_o
);

  logic [ihe_pkg::CNT_W-1:0] mem [2**ihe_pkg::ADDR_W];

  // Write one entry, read two
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_o <= mem[req_i.raddr_a];
    rd_b_o <= mem[req_i.raddr_b];
  end

endmodule

/* rtl/ihe_core.sv */
// Sequencer and read-modify-write datapath over the integral count table.
module ihe_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ihe_pkg::cfg_t             cfg_i,
  input  logic                      start_i,
  input  ihe_pkg::item_t            item_i,
  output logic                      busy_o,
  output ihe_pkg::mem_req_t         mem_req_o,
  input  logic [ihe_pkg::CNT_W-1:0] rd_a_i,
  input  logic [ihe_pkg::CNT_W-1:0] rd_b_i,
  output logic                      rect_valid_o,
  output logic [ihe_pkg::CNT_W-1:0] rect_count_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_QRY1 = 4'b0100,
    ST_QRY2 = 4'b1000
  } state_e;

  typedef struct packed {
    logic                       valid;
    ihe_pkg::rsp_op_e           op;
    logic                       use_hold;
    logic                       row0;
    logic                       col0;
    logic                       hit;
    logic [ihe_pkg::BIN_W-1:0]  bin;
    logic [ihe_pkg::ADDR_W-1:0] waddr;
  } rsp_t;

  state_e                      state_q, state_d;
  logic [ihe_pkg::BIN_W-1:0]   bin_q, bin_d;
  logic                        dg_have_q, dg_have_d;
  logic [ihe_pkg::COL_W-1:0]   lcol_q, lcol_d;
  logic [ihe_pkg::ROW_W-1:0]   lrow_q, lrow_d;
  logic [ihe_pkg::BCNT_W-1:0]  prev_bins_q, prev_bins_d;
  rsp_t                        rsp_q, rsp_d;

  logic [ihe_pkg::LABEL_W-1:0] label_q;
  logic [ihe_pkg::COL_W-1:0]   tu_q, bu_q;
  logic [ihe_pkg::ROW_W-1:0]   tv_q, bv_q;
  logic [ihe_pkg::BIN_W-1:0]   qbin_q;
  logic                        qok_q;

  logic [ihe_pkg::CNT_W-1:0]   dg_hold_q, dg_hold_d;
  logic [ihe_pkg::CNT_W-1:0]   sum_q, sum_d;
  logic [ihe_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        valid_q, valid_d;

  logic [ihe_pkg::CNT_W-1:0]   dg_cache [ihe_pkg::MAX_BINS];
  logic [ihe_pkg::CNT_W-1:0]   cache_rd_q;
  logic                        cache_we;

  logic                        accept;
  logic                        need_dg;
  logic                        last_bin;
  logic [ihe_pkg::WCNT_W-1:0]  col_nx;
  logic [ihe_pkg::HCNT_W-1:0]  row_nx;
  logic [ihe_pkg::ADDR_W-1:0]  up_addr, lf_addr, dg_addr;
  logic [ihe_pkg::ADDR_W-1:0]  raddr_a, raddr_b;
  logic [ihe_pkg::CNT_W-1:0]   up_val, lf_val, dg_val, new_val;

  assign busy_o = (state_q != ST_IDLE) || rsp_q.valid;
  assign accept = start_i && !busy_o;

  // Neighbour addresses of the cell under update
  assign up_addr = {bin_q, lrow_q - ihe_pkg::ROW_W'(1), lcol_q};
  assign lf_addr = {bin_q, lrow_q, lcol_q - ihe_pkg::COL_W'(1)};
  assign dg_addr = {bin_q, lrow_q - ihe_pkg::ROW_W'(1), lcol_q - ihe_pkg::COL_W'(1)};

  // The diagonal comes from the cache only for bins updated at the previous pixel
  assign need_dg  = (lrow_q != '0) && (lcol_q != '0) && !dg_have_q
                    && (ihe_pkg::BCNT_W'(bin_q) >= prev_bins_q);
  assign last_bin = (ihe_pkg::BCNT_W'(bin_q) + ihe_pkg::BCNT_W'(1)) >= cfg_i.num_bins;
  assign col_nx   = ihe_pkg::WCNT_W'(lcol_q) + ihe_pkg::WCNT_W'(1);
  assign row_nx   = ihe_pkg::HCNT_W'(lrow_q) + ihe_pkg::HCNT_W'(1);

  // Issue side: sequence bins of a load, corner pairs of a query
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    dg_have_d   = dg_have_q;
    lcol_d      = lcol_q;
    lrow_d      = lrow_q;
    prev_bins_d = prev_bins_q;
    rsp_d       = '0;
    raddr_a     = '0;
    raddr_b     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = (item_i.kind == ihe_pkg::KIND_LOAD) ? ST_LOAD : ST_QRY1;
          bin_d     = '0;
          dg_have_d = 1'b0;
        end
      end
      ST_LOAD: begin
        if (need_dg) begin
          raddr_a   = dg_addr;
          rsp_d.valid = 1'b1;
          rsp_d.op  = ihe_pkg::RSP_DG;
          rsp_d.bin = bin_q;
          dg_have_d = 1'b1;
        end else begin
          raddr_a        = up_addr;
          raddr_b        = lf_addr;
          rsp_d.valid    = 1'b1;
          rsp_d.op       = ihe_pkg::RSP_CELL;
          rsp_d.use_hold = dg_have_q;
          rsp_d.row0     = (lrow_q == '0);
          rsp_d.col0     = (lcol_q == '0);
          rsp_d.hit      = (label_q == ihe_pkg::LABEL_W'(bin_q));
          rsp_d.bin      = bin_q;
          rsp_d.waddr    = {bin_q, lrow_q, lcol_q};
          dg_have_d      = 1'b0;
          if (last_bin) begin
            state_d     = ST_IDLE;
            prev_bins_d = cfg_i.num_bins;
            // Advance the raster position
            if (col_nx >= cfg_i.width) begin
              lcol_d = '0;
              if (row_nx >= cfg_i.height) lrow_d = '0;
              else lrow_d = row_nx[ihe_pkg::ROW_W-1:0];
            end else begin
              lcol_d = col_nx[ihe_pkg::COL_W-1:0];
            end
          end else begin
            bin_d = bin_q + ihe_pkg::BIN_W'(1);
          end
        end
      end
      ST_QRY1: begin
        raddr_a     = {qbin_q, tv_q, tu_q};
        raddr_b     = {qbin_q, bv_q, bu_q};
        rsp_d.valid = 1'b1;
        rsp_d.op    = ihe_pkg::RSP_Q1;
        state_d     = ST_QRY2;
      end
      ST_QRY2: begin
        raddr_a     = {qbin_q, tv_q, bu_q};
        raddr_b     = {qbin_q, bv_q, tu_q};
        rsp_d.valid = 1'b1;
        rsp_d.op    = ihe_pkg::RSP_Q2;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Response side: combine read data and write back
  always_comb begin
    up_val    = rsp_q.row0 ? '0 : rd_a_i;
    lf_val    = rsp_q.col0 ? '0 : rd_b_i;
    dg_val    = (rsp_q.row0 || rsp_q.col0) ? '0 : (rsp_q.use_hold ? dg_hold_q : cache_rd_q);
    new_val   = up_val + lf_val - dg_val + ihe_pkg::CNT_W'(rsp_q.hit);
    cache_we  = 1'b0;
    dg_hold_d = dg_hold_q;
    sum_d     = sum_q;
    count_d   = count_q;
    valid_d   = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = rsp_q.waddr;
    mem_req_o.wdata = new_val;
    if (rsp_q.valid) begin
      case (rsp_q.op)
        ihe_pkg::RSP_DG: begin
          dg_hold_d = rd_a_i;
        end
        ihe_pkg::RSP_CELL: begin
          mem_req_o.we = 1'b1;
          cache_we     = 1'b1;
        end
        ihe_pkg::RSP_Q1: begin
          sum_d = rd_a_i + rd_b_i;
        end
        ihe_pkg::RSP_Q2: begin
          count_d = qok_q ? (sum_q - rd_a_i - rd_b_i) : '0;
          valid_d = 1'b1;
        end
        default: begin
          valid_d = 1'b0;
        end
      endcase
    end
    mem_req_o.raddr_a = raddr_a;
    mem_req_o.raddr_b = raddr_b;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bin_q       <= '0;
      dg_have_q   <= 1'b0;
      lcol_q      <= '0;
      lrow_q      <= '0;
      prev_bins_q <= '0;
      rsp_q       <= '0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      bin_q       <= bin_d;
      dg_have_q   <= dg_have_d;
      lcol_q      <= lcol_d;
      lrow_q      <= lrow_d;
      prev_bins_q <= prev_bins_d;
      rsp_q       <= rsp_d;
      valid_q     <= valid_d;
    end
  end

  // Capture the accepted beat and hold datapath values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      label_q <= item_i.label;
      tu_q    <= ihe_pkg::clamp_col(item_i.left_col);
      tv_q    <= ihe_pkg::clamp_row(item_i.top_row);
      bu_q    <= ihe_pkg::clamp_col(item_i.right_col);
      bv_q    <= ihe_pkg::clamp_row(item_i.bottom_row);
      qbin_q  <= item_i.query_bin[ihe_pkg::BIN_W-1:0];
      qok_q   <= (32'(item_i.query_bin) < 32'(cfg_i.num_bins));
    end
    dg_hold_q <= dg_hold_d;
    sum_q     <= sum_d;
    count_q   <= count_d;
  end

  // Per-bin copy of the up neighbour, the diagonal of the next pixel
  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      dg_cache[rsp_q.bin] <= up_val;
    end
    cache_rd_q <= dg_cache[bin_q];
  end

  assign rect_valid_o = valid_q;
  assign rect_count_o = count_q;

endmodule

/* rtl/integral_histogram_engine.sv */
// Top level of the integral histogram engine: configuration registers and the table.
//
// A load beat updates one 13-bit integral count per bin in use at the next raster position;
// a query beat reads four corners of one bin and returns their signed combination modulo
// 2^13. Beats are taken when start is high and busy is low. A load keeps busy high while it
// steps through the bins in use, with an extra diagonal read for every bin not updated at the
// previous pixel of the same row (away from the first row and column), as the table's two read
// ports fetch the up and left neighbours of one bin per cycle between diagonal reads while a
// small per-bin cache supplies the other diagonals. A query keeps busy high through QRY1, QRY2
// and its response; its registered result appears on rect_count_o with rect_valid_o high for
// exactly one cycle; the receiver cannot stall it. The table comes out of reset undefined and
// needs no clearing pass: a full frame must load before any query.
module integral_histogram_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ihe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ihe_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [ihe_pkg::LABEL_W-1:0]   label_i,
  input  logic [ihe_pkg::COORD_W-1:0]   left_col_i,
  input  logic [ihe_pkg::COORD_W-1:0]   top_row_i,
  input  logic [ihe_pkg::COORD_W-1:0]   right_col_i,
  input  logic [ihe_pkg::COORD_W-1:0]   bottom_row_i,
  input  logic [ihe_pkg::LABEL_W-1:0]   query_bin_i,
  output logic                          rect_valid_o,
  output logic [ihe_pkg::CNT_W-1:0]     rect_count_o
);

  localparam logic [ihe_pkg::CFG_W-1:0] WIDTH_RST =
    ihe_pkg::clamp_reg(ihe_pkg::CFG_W'(64), ihe_pkg::MAX_WIDTH);
  localparam logic [ihe_pkg::CFG_W-1:0] HEIGHT_RST =
    ihe_pkg::clamp_reg(ihe_pkg::CFG_W'(64), ihe_pkg::MAX_HEIGHT);
  localparam logic [ihe_pkg::CFG_W-1:0] BINS_RST =
    ihe_pkg::clamp_reg(ihe_pkg::CFG_W'(64), ihe_pkg::MAX_BINS);

  ihe_pkg::cfg_t             cfg_q;
  ihe_pkg::item_t            item;
  ihe_pkg::mem_req_t         mem_req;
  logic [ihe_pkg::CNT_W-1:0] rd_a, rd_b;
  logic [ihe_pkg::CFG_W-1:0] width_cl, height_cl, bins_cl;

  // Clamp written values to the usable range
  assign width_cl  = ihe_pkg::clamp_reg(ihe_pkg::CFG_W'(cfg_wdata_i[ihe_pkg::WREG_W-1:0]),
                                        ihe_pkg::MAX_WIDTH);
  assign height_cl = ihe_pkg::clamp_reg(ihe_pkg::CFG_W'(cfg_wdata_i[ihe_pkg::HREG_W-1:0]),
                                        ihe_pkg::MAX_HEIGHT);
  assign bins_cl   = ihe_pkg::clamp_reg(cfg_wdata_i[ihe_pkg::BREG_W-1:0], ihe_pkg::MAX_BINS);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= WIDTH_RST[ihe_pkg::WCNT_W-1:0];
      cfg_q.height   <= HEIGHT_RST[ihe_pkg::HCNT_W-1:0];
      cfg_q.num_bins <= BINS_RST[ihe_pkg::BCNT_W-1:0];
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ihe_pkg::REG_ACTIVE_WIDTH: begin
          cfg_q.width <= width_cl[ihe_pkg::WCNT_W-1:0];
        end
        ihe_pkg::REG_ACTIVE_HEIGHT: begin
          cfg_q.height <= height_cl[ihe_pkg::HCNT_W-1:0];
        end
        ihe_pkg::REG_ACTIVE_BINS: begin
          cfg_q.num_bins <= bins_cl[ihe_pkg::BCNT_W-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Bundle the input beat
  assign item.kind       = kind_i;
  assign item.label      = label_i;
  assign item.left_col   = left_col_i;
  assign item.top_row    = top_row_i;
  assign item.right_col  = right_col_i;
  assign item.bottom_row = bottom_row_i;
  assign item.query_bin  = query_bin_i;

  ihe_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (start),
    .item_i       (item),
    .busy_o       (busy),
    .mem_req_o    (mem_req),
    .rd_a_i       (rd_a),
    .rd_b_i       (rd_b),
    .rect_valid_o (rect_valid_o),
    .rect_count_o (rect_count_o)
  );

  ihe_table_ram u_table (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // Table writes happen only while an item is in progress
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> busy)
    else $error("table written while idle");

  // Every accepted query yields its result
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == ihe_pkg::KIND_QUERY) |-> ##4 rect_valid_o)
    else $error("query result missing");

  // No result without an earlier accepted query
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> $past(start && !busy && kind_i == ihe_pkg::KIND_QUERY, 4))
    else $error("result without query");

  // Results are never on consecutive cycles
  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |=> !rect_valid_o)
    else $error("back-to-back results");

endmodule
